// ----- hdl/sla_pkg.sv -----
// Shared types, codes and default sizes for the sectioned slot allocator.
// No dependencies; sla_vmem, sla_addr_calc, the top level and sla_port_chk refer to this package.
`default_nettype none

package sla_pkg;

    // Default geometry
    localparam int SECTIONS_DEF     = 4;
    localparam int SLOTS_EACH_DEF   = 64;
    localparam int DATA_BYTES_DEF   = 128;
    localparam int MAX_NAME_DEF     = 14;
    localparam int RECORD_BYTES_DEF = 16;

    // Configuration port
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 2'd2;
    localparam logic [REG_W-1:0] ENTRY_BASE_RST = 16'd8;
    localparam logic [REG_W-1:0] DATA_BASE_RST  = 16'd4096;
    localparam logic [REG_W-1:0] STRIDE_RST     = 16'd8192;

    typedef enum logic [2:0] {
        OP_OCCUPY  = 3'd0,
        OP_UPDATE  = 3'd1,
        OP_FREE    = 3'd2,
        OP_APPEND  = 3'd3,
        OP_READ    = 3'd4,
        OP_RESTORE = 3'd5,
        OP_FINISH  = 3'd6,
        OP_FORMAT  = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_NOT_INIT     = 4'd1,
        ST_BAD_NAME     = 4'd2,
        ST_BAD_SECTION  = 4'd3,
        ST_SECTION_FULL = 4'd4,
        ST_BAD_SLOT     = 4'd5,
        ST_NO_DATA      = 4'd6,
        ST_TOO_BIG      = 4'd7,
        ST_BUF_SMALL    = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EVAL = 2'd1,
        S_ADDR = 2'd2
    } t_state;

    typedef struct packed {
        t_op        operation;
        logic [7:0] section;
        logic [7:0] entry;
        logic [7:0] name_len;
        logic [7:0] offset_value;
        logic [7:0] transfer_size;
        logic       flag;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [5:0]  position;
        logic [15:0] entry_address;
        logic [15:0] data_addr;
        logic [7:0]  transfer_length;
        logic [7:0]  stored_offset;
    } t_rsp;

    // Control of one state memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_mem_ctl;

    // Slot addresses in EEPROM
    typedef struct packed {
        logic [15:0] rec;
        logic [15:0] dat;
    } t_addr;

endpackage

`default_nettype wire

// ----- hdl/sla_vmem.sv -----
// Synchronous state memory, one write and one registered read port, with a
// valid bit per entry so that reset and format clear it at once. Uses sla_pkg.
`default_nettype none

module sla_vmem #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 64,
    parameter int AW    = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sla_pkg::t_mem_ctl i_ctl,
    input  wire logic [AW-1:0]     i_rd_addr,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    output logic [WIDTH-1:0]       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd;
    logic             rd_in_range;

    assign rd_in_range = ({1'b0, i_rd_addr} < (AW+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clr) begin
            r_vld <= '0;
        end else if (i_ctl.wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Entries never written since reset or format read as zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd <= (rd_in_range && r_vld[i_rd_addr]) ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire

// ----- hdl/sla_free_find.sv -----
// Lowest free entry of one section's busy row, and a full flag.
// Uses no package items.
`default_nettype none

module sla_free_find #(
    parameter int SLOTS_EACH = 64,
    parameter int ENT_W      = 6
) (
    input  wire logic [SLOTS_EACH-1:0] i_row,
    output logic [ENT_W-1:0]           o_idx,
    output logic                       o_full
);

    logic [SLOTS_EACH-1:0] lowest_zero;

    // One-hot of the lowest clear bit
    assign lowest_zero = ~i_row & (i_row + SLOTS_EACH'(1));
    assign o_full      = &i_row;

    always_comb begin
        o_idx = '0;
        for (int i = 0; i < SLOTS_EACH; i++) begin
            o_idx = o_idx | (lowest_zero[i] ? ENT_W'(i) : '0);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sla_addr_calc.sv -----
// EEPROM record and data start address of one slot from the base registers.
// Uses sla_pkg::t_addr.
`default_nettype none

module sla_addr_calc #(
    parameter int SLOTS_EACH   = 64,
    parameter int DATA_BYTES   = 128,
    parameter int RECORD_BYTES = 16,
    parameter int SEC_W        = 2,
    parameter int ENT_W        = 6
) (
    input  wire logic [15:0]      i_entry_base,
    input  wire logic [15:0]      i_data_base,
    input  wire logic [15:0]      i_stride,
    input  wire logic [SEC_W-1:0] i_sec,
    input  wire logic [ENT_W-1:0] i_ent,
    output sla_pkg::t_addr        o_addr
);

    logic [15:0] slot_num;
    logic [15:0] rec_off;
    logic [15:0] sec_off;
    logic [15:0] ent_off;

    assign slot_num = 16'(i_sec) * 16'(SLOTS_EACH) + 16'(i_ent);
    assign rec_off  = slot_num * 16'(RECORD_BYTES);
    assign sec_off  = 16'(i_sec) * i_stride;
    assign ent_off  = 16'(i_ent) * 16'(DATA_BYTES);

    assign o_addr.rec = i_entry_base + rec_off;
    assign o_addr.dat = i_data_base + sec_off + ent_off;

endmodule

`default_nettype wire

// ----- hdl/sectioned_slot_allocator.sv -----
// Sectioned slot allocator: busy bitmap and append offset bookkeeping for an
// EEPROM slot table. Uses sla_pkg, sla_vmem, sla_free_find, sla_addr_calc.
// The result word strobes on o_done after the request passes evaluate and address.
// One request at a time, taken only while idle (memory read, evaluate, address and
// write back); busy stays high in evaluate and address, the result shows while idle.
// Reset (synchronous, active low): clear ready, busy bits and offsets; load defaults.
`default_nettype none

module sectioned_slot_allocator #(
    parameter int SECTIONS     = sla_pkg::SECTIONS_DEF,
    parameter int SLOTS_EACH   = sla_pkg::SLOTS_EACH_DEF,
    parameter int DATA_BYTES   = sla_pkg::DATA_BYTES_DEF,
    parameter int MAX_NAME     = sla_pkg::MAX_NAME_DEF,
    parameter int RECORD_BYTES = sla_pkg::RECORD_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire sla_pkg::t_req                 i_req,
    output logic                               o_done,
    output sla_pkg::t_rsp                      o_rsp,
    input  wire logic                          i_cfg_we,
    input  wire logic [sla_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sla_pkg::REG_W-1:0]     i_cfg_data
);

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int ENT_W = (SLOTS_EACH > 1) ? $clog2(SLOTS_EACH) : 1;
    localparam int NSLOT = SECTIONS * SLOTS_EACH;
    localparam int G_W   = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_entry_base;
    logic [15:0] r_data_base;
    logic [15:0] r_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_base <= sla_pkg::ENTRY_BASE_RST;
            r_data_base  <= sla_pkg::DATA_BASE_RST;
            r_stride     <= sla_pkg::STRIDE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sla_pkg::REG_ENTRY_BASE: r_entry_base <= i_cfg_data;
                sla_pkg::REG_DATA_BASE:  r_data_base  <= i_cfg_data;
                sla_pkg::REG_STRIDE:     r_stride     <= i_cfg_data;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    sla_pkg::t_state r_state, n_state;
    logic            accept;

    assign accept = start && (r_state == sla_pkg::S_IDLE);
    assign busy   = (r_state != sla_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sla_pkg::S_IDLE: if (start) n_state = sla_pkg::S_EVAL;
            sla_pkg::S_EVAL: n_state = sla_pkg::S_ADDR;
            sla_pkg::S_ADDR: n_state = sla_pkg::S_IDLE;
            default:         n_state = sla_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Request capture; memory reads go out on the same edge
    // ------------------------------------------------------------------
    sla_pkg::t_req    r_req;
    logic             r_inrange;
    logic [SEC_W-1:0] in_sec;
    logic [ENT_W-1:0] in_ent;
    logic [G_W-1:0]   in_slot;

    assign in_sec  = i_req.section[SEC_W-1:0];
    assign in_ent  = i_req.entry[ENT_W-1:0];
    assign in_slot = G_W'(32'(in_sec) * SLOTS_EACH + 32'(in_ent));

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= i_req;
            r_inrange <= (i_req.section < 8'(SECTIONS)) && (i_req.entry < 8'(SLOTS_EACH));
        end
    end

    // ------------------------------------------------------------------
    // State memories: busy rows per section, append offsets per slot
    // ------------------------------------------------------------------
    sla_pkg::t_mem_ctl      busy_ctl, off_ctl;
    logic [SLOTS_EACH-1:0]  row_rd, row_wr;
    logic [7:0]             off_rd;
    logic [G_W-1:0]         off_wr_addr;
    logic [SEC_W-1:0]       r_sec_idx;

    // Write-back flags set while evaluating, used in the address cycle
    logic             r_wr_busy, r_busy_val, r_wr_off, r_fmt;
    logic [ENT_W-1:0] r_tgt;
    logic [7:0]       r_new_off;

    assign r_sec_idx = r_req.section[SEC_W-1:0];

    always_comb begin
        busy_ctl.rd_en = accept;
        busy_ctl.wr_en = (r_state == sla_pkg::S_ADDR) && r_wr_busy;
        busy_ctl.clr   = (r_state == sla_pkg::S_ADDR) && r_fmt;
        off_ctl.rd_en  = accept;
        off_ctl.wr_en  = (r_state == sla_pkg::S_ADDR) && r_wr_off;
        off_ctl.clr    = (r_state == sla_pkg::S_ADDR) && r_fmt;
    end

    always_comb begin
        row_wr        = row_rd;
        row_wr[r_tgt] = r_busy_val;
    end

    assign off_wr_addr = G_W'(32'(r_sec_idx) * SLOTS_EACH + 32'(r_tgt));

    sla_vmem #(
        .DEPTH (SECTIONS),
        .WIDTH (SLOTS_EACH),
        .AW    (SEC_W)
    ) u_busy_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (busy_ctl),
        .i_rd_addr (in_sec),
        .i_wr_addr (r_sec_idx),
        .i_wr_data (row_wr),
        .o_rd_data (row_rd)
    );

    sla_vmem #(
        .DEPTH (NSLOT),
        .WIDTH (8),
        .AW    (G_W)
    ) u_off_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (off_ctl),
        .i_rd_addr (in_slot),
        .i_wr_addr (off_wr_addr),
        .i_wr_data (r_new_off),
        .o_rd_data (off_rd)
    );

    // ------------------------------------------------------------------
    // Evaluate: status checks in priority order, first free entry
    // ------------------------------------------------------------------
    logic             r_ready;
    logic [ENT_W-1:0] ff_idx;
    logic             ff_full;
    logic             sec_ok, ent_ok, slot_busy;
    logic [7:0]       stored;
    sla_pkg::t_status chk;

    sla_free_find #(
        .SLOTS_EACH (SLOTS_EACH),
        .ENT_W      (ENT_W)
    ) u_free_find (
        .i_row  (row_rd),
        .o_idx  (ff_idx),
        .o_full (ff_full)
    );

    assign sec_ok    = (r_req.section < 8'(SECTIONS));
    assign ent_ok    = (r_req.entry < 8'(SLOTS_EACH));
    assign slot_busy = row_rd[r_req.entry[ENT_W-1:0]];
    assign stored    = r_inrange ? off_rd : 8'd0;

    always_comb begin
        if (!sec_ok) begin
            chk = sla_pkg::ST_BAD_SECTION;
        end else if (!ent_ok) begin
            chk = sla_pkg::ST_BAD_SLOT;
        end else if (!r_ready) begin
            chk = sla_pkg::ST_NOT_INIT;
        end else if (!slot_busy) begin
            chk = sla_pkg::ST_BAD_SLOT;
        end else begin
            chk = sla_pkg::ST_OK;
        end
    end

    sla_pkg::t_status e_status;
    logic             e_zero, e_wr_busy, e_busy_val, e_wr_off, e_fmt, e_ready;
    logic             e_offb, e_add_old;
    logic [ENT_W-1:0] e_tgt;
    logic [7:0]       e_new_off, e_len;
    logic [5:0]       e_pos;

    always_comb begin
        e_status   = sla_pkg::ST_OK;
        e_zero     = 1'b0;
        e_wr_busy  = 1'b0;
        e_busy_val = 1'b0;
        e_wr_off   = 1'b0;
        e_fmt      = 1'b0;
        e_ready    = r_ready;
        e_offb     = 1'b0;
        e_add_old  = 1'b0;
        e_tgt      = r_req.entry[ENT_W-1:0];
        e_new_off  = stored;
        e_len      = 8'd0;
        e_pos      = 6'd0;
        unique case (r_req.operation)
            sla_pkg::OP_OCCUPY: begin
                if (!r_ready) begin
                    e_status = sla_pkg::ST_NOT_INIT;
                end else if (r_req.name_len == 8'd0 ||
                             r_req.name_len > 8'(MAX_NAME)) begin
                    e_status = sla_pkg::ST_BAD_NAME;
                end else if (!sec_ok) begin
                    e_status = sla_pkg::ST_BAD_SECTION;
                end else if (ff_full) begin
                    e_status = sla_pkg::ST_SECTION_FULL;
                end else begin
                    e_tgt      = ff_idx;
                    e_pos      = 6'(ff_idx);
                    e_wr_busy  = 1'b1;
                    e_busy_val = 1'b1;
                    e_wr_off   = 1'b1;
                    e_new_off  = 8'd0;
                end
            end
            sla_pkg::OP_UPDATE: begin
                if (chk != sla_pkg::ST_OK) begin
                    e_status = chk;
                end else if (r_req.offset_value > 8'(DATA_BYTES)) begin
                    e_status = sla_pkg::ST_BAD_SLOT;
                end else begin
                    e_wr_off  = 1'b1;
                    e_new_off = r_req.offset_value;
                    e_offb    = 1'b1;
                end
            end
            sla_pkg::OP_FREE: begin
                if (chk != sla_pkg::ST_OK) begin
                    e_status = chk;
                end else begin
                    e_wr_busy = 1'b1;
                    e_wr_off  = 1'b1;
                    e_new_off = 8'd0;
                end
            end
            sla_pkg::OP_APPEND: begin
                if (r_req.transfer_size == 8'd0) begin
                    e_status = sla_pkg::ST_NO_DATA;
                end else if (chk != sla_pkg::ST_OK) begin
                    e_status = chk;
                end else if (stored > 8'(DATA_BYTES)) begin
                    e_status = sla_pkg::ST_BAD_SLOT;
                end else if (r_req.transfer_size > 8'(DATA_BYTES) - stored) begin
                    e_status = sla_pkg::ST_TOO_BIG;
                end else begin
                    e_wr_off  = 1'b1;
                    e_new_off = stored + r_req.transfer_size;
                    e_len     = r_req.transfer_size;
                    e_offb    = 1'b1;
                    e_add_old = 1'b1;
                end
            end
            sla_pkg::OP_READ: begin
                if (chk != sla_pkg::ST_OK) begin
                    e_status = chk;
                end else if (stored > 8'(DATA_BYTES)) begin
                    e_status = sla_pkg::ST_BAD_SLOT;
                end else if (r_req.transfer_size < stored) begin
                    e_status = sla_pkg::ST_BUF_SMALL;
                end else begin
                    e_len  = stored;
                    e_offb = 1'b1;
                end
            end
            sla_pkg::OP_RESTORE: begin
                if (!sec_ok) begin
                    e_status = sla_pkg::ST_BAD_SECTION;
                end else if (!ent_ok) begin
                    e_status = sla_pkg::ST_BAD_SLOT;
                end else begin
                    e_wr_busy  = 1'b1;
                    e_busy_val = r_req.flag;
                    e_wr_off   = 1'b1;
                    e_new_off  = r_req.offset_value;
                end
            end
            sla_pkg::OP_FINISH: begin
                e_ready  = r_req.flag;
                e_zero   = 1'b1;
                e_status = r_req.flag ? sla_pkg::ST_OK : sla_pkg::ST_NOT_INIT;
            end
            sla_pkg::OP_FORMAT: begin
                e_fmt     = 1'b1;
                e_ready   = 1'b0;
                e_new_off = 8'd0;
            end
            default: ;
        endcase
        // Any failed check but finish's leaves state alone and zeroes the address fields
        if (r_req.operation != sla_pkg::OP_FINISH && e_status != sla_pkg::ST_OK) begin
            e_zero    = 1'b1;
            e_wr_busy = 1'b0;
            e_wr_off  = 1'b0;
            e_new_off = stored;
            e_len     = 8'd0;
            e_pos     = 6'd0;
        end
    end

    sla_pkg::t_status r_status;
    logic             r_zero, r_offb, r_add_old, r_ready_nx;
    logic [7:0]       r_len, r_old_off;
    logic [5:0]       r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_busy <= 1'b0;
            r_wr_off  <= 1'b0;
            r_fmt     <= 1'b0;
        end else if (r_state == sla_pkg::S_EVAL) begin
            r_wr_busy <= e_wr_busy;
            r_wr_off  <= e_wr_off;
            r_fmt     <= e_fmt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sla_pkg::S_EVAL) begin
            r_status   <= e_status;
            r_zero     <= e_zero;
            r_busy_val <= e_busy_val;
            r_ready_nx <= e_ready;
            r_offb     <= e_offb;
            r_add_old  <= e_add_old;
            r_tgt      <= e_tgt;
            r_new_off  <= e_new_off;
            r_len      <= e_len;
            r_pos      <= e_pos;
            r_old_off  <= stored;
        end
    end

    // ------------------------------------------------------------------
    // Address cycle: EEPROM addresses, write back, result word
    // ------------------------------------------------------------------
    sla_pkg::t_addr slot_addr;
    logic [15:0]    eaddr, daddr;

    sla_addr_calc #(
        .SLOTS_EACH   (SLOTS_EACH),
        .DATA_BYTES   (DATA_BYTES),
        .RECORD_BYTES (RECORD_BYTES),
        .SEC_W        (SEC_W),
        .ENT_W        (ENT_W)
    ) u_addr_calc (
        .i_entry_base (r_entry_base),
        .i_data_base  (r_data_base),
        .i_stride     (r_stride),
        .i_sec        (r_sec_idx),
        .i_ent        (r_tgt),
        .o_addr       (slot_addr)
    );

    always_comb begin
        if (r_zero) begin
            eaddr = 16'd0;
            daddr = 16'd0;
        end else if (r_fmt) begin
            eaddr = r_entry_base;
            daddr = 16'd0;
        end else begin
            // offset byte sits right after the NUL-terminated name
            eaddr = r_offb ? slot_addr.rec + 16'(MAX_NAME + 1) : slot_addr.rec;
            daddr = slot_addr.dat + (r_add_old ? 16'(r_old_off) : 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            o_done <= (r_state == sla_pkg::S_ADDR);
            if (r_state == sla_pkg::S_ADDR) begin
                r_ready <= r_ready_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sla_pkg::S_ADDR) begin
            o_rsp.status          <= r_status;
            o_rsp.position        <= r_pos;
            o_rsp.entry_address   <= eaddr;
            o_rsp.data_addr       <= daddr;
            o_rsp.transfer_length <= r_len;
            o_rsp.stored_offset   <= r_new_off;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sla_port_chk.sv -----
// Port-level checks on the sectioned slot allocator, bound to its top level.
// Uses sla_pkg for the status codes.
`default_nettype none

module sla_port_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_done,
    input wire sla_pkg::t_rsp o_rsp
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("result word did not follow a request");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a request");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe outside the end of a request");

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != sla_pkg::ST_OK)) |->
            (o_rsp.position == 6'd0 && o_rsp.transfer_length == 8'd0 &&
             o_rsp.data_addr == 16'd0 && o_rsp.entry_address == 16'd0))
        else $error("failed request carries addresses or length");

endmodule

bind sectioned_slot_allocator sla_port_chk u_port_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sectioned_slot_allocator: random and directed slot table
// commands, with an in-bench model of the bitmap, offsets and ready flag. Needs sla_pkg.

module tb;
    import sla_pkg::*;

    localparam int NSEC         = SECTIONS_DEF;
    localparam int SLOTS        = SLOTS_EACH_DEF;
    localparam int DATA_BYTES   = DATA_BYTES_DEF;
    localparam int MAX_NAME     = MAX_NAME_DEF;
    localparam int RECORD_BYTES = RECORD_BYTES_DEF;
    localparam int LATENCY      = 3;
    localparam int CYCLE_LIMIT  = 400000;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_req                 i_req      = '0;
    logic                 o_done;
    t_rsp                 o_rsp;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [REG_W-1:0]     i_cfg_data = '0;

    sectioned_slot_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Mirror of the block's table: one busy map per section, one append offset
    // per slot, the ready flag, and the three layout registers.
    logic [SLOTS-1:0] occupied [NSEC];
    logic [7:0]       fill_level [NSEC*SLOTS];
    bit               table_ready;
    logic [15:0]      rec_base;
    logic [15:0]      dat_base;
    logic [15:0]      sec_stride;

    t_req cmd_backlog [$];   // command words not yet presented
    t_rsp due_rsp [$];       // result words owed by the block, oldest first
    int   gap_pct;           // chance in a hundred that the sender idles a cycle
    int   mismatches;
    int   rsp_seen;
    int   cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [15:0] record_at(int unsigned sec, int unsigned ent);
        return 16'(rec_base + (sec * SLOTS + ent) * RECORD_BYTES);
    endfunction

    // Offset byte sits right after the NUL-terminated name in the record.
    function automatic logic [15:0] offset_byte_at(int unsigned sec, int unsigned ent);
        return 16'(record_at(sec, ent) + MAX_NAME + 1);
    endfunction

    function automatic logic [15:0] data_at(int unsigned sec, int unsigned ent);
        return 16'(dat_base + sec * sec_stride + ent * DATA_BYTES);
    endfunction

    // Shared gate for update, free, append and read; order matters.
    function automatic t_status slot_check(int unsigned sec, int unsigned ent);
        if (sec >= NSEC) return ST_BAD_SECTION;
        if (ent >= SLOTS) return ST_BAD_SLOT;
        if (!table_ready) return ST_NOT_INIT;
        if (!occupied[sec][ent]) return ST_BAD_SLOT;
        return ST_OK;
    endfunction

    // Apply one command word to the mirror and return the result word it owes.
    function automatic t_rsp table_response(t_req c);
        int unsigned sec, ent, slot, cur, e;
        bit          in_range;
        t_status     err;
        t_rsp        r;
        sec      = c.section;
        ent      = c.entry;
        in_range = (sec < NSEC) && (ent < SLOTS);
        slot     = in_range ? sec * SLOTS + ent : 0;
        cur      = in_range ? fill_level[slot] : 0;
        err      = ST_OK;
        r        = '0;
        r.stored_offset = 8'(cur);
        case (c.operation)
            OP_OCCUPY: begin
                if (!table_ready) err = ST_NOT_INIT;
                else if (c.name_len == 0 || c.name_len > MAX_NAME) err = ST_BAD_NAME;
                else if (sec >= NSEC) err = ST_BAD_SECTION;
                else begin
                    // entry field is ignored: take the lowest free entry
                    e = 0;
                    while (e < SLOTS && occupied[sec][e]) e++;
                    if (e >= SLOTS) begin
                        err = ST_SECTION_FULL;
                    end else begin
                        occupied[sec][e]         = 1'b1;
                        fill_level[sec*SLOTS+e]  = '0;
                        r.position               = 6'(e);
                        r.entry_address          = record_at(sec, e);
                        r.data_addr              = data_at(sec, e);
                        r.stored_offset          = '0;
                    end
                end
            end
            OP_UPDATE: begin
                err = slot_check(sec, ent);
                if (err == ST_OK) begin
                    if (c.offset_value > DATA_BYTES) begin
                        err = ST_BAD_SLOT;
                    end else begin
                        fill_level[slot] = c.offset_value;
                        r.entry_address  = offset_byte_at(sec, ent);
                        r.data_addr      = data_at(sec, ent);
                        r.stored_offset  = c.offset_value;
                    end
                end
            end
            OP_FREE: begin
                err = slot_check(sec, ent);
                if (err == ST_OK) begin
                    occupied[sec][ent] = 1'b0;
                    fill_level[slot]   = '0;
                    r.entry_address    = record_at(sec, ent);
                    r.data_addr        = data_at(sec, ent);
                    r.stored_offset    = '0;
                end
            end
            OP_APPEND: begin
                if (c.transfer_size == 0) err = ST_NO_DATA;
                else err = slot_check(sec, ent);
                if (err == ST_OK) begin
                    if (cur > DATA_BYTES) err = ST_BAD_SLOT;
                    else if (c.transfer_size > DATA_BYTES - cur) err = ST_TOO_BIG;
                    else begin
                        r.entry_address   = offset_byte_at(sec, ent);
                        r.data_addr       = 16'(data_at(sec, ent) + cur);
                        r.transfer_length = c.transfer_size;
                        fill_level[slot]  = 8'(cur + c.transfer_size);
                        r.stored_offset   = fill_level[slot];
                    end
                end
            end
            OP_READ: begin
                err = slot_check(sec, ent);
                if (err == ST_OK) begin
                    if (cur > DATA_BYTES) err = ST_BAD_SLOT;
                    else if (c.transfer_size < cur) err = ST_BUF_SMALL;
                    else begin
                        r.entry_address   = offset_byte_at(sec, ent);
                        r.data_addr       = data_at(sec, ent);
                        r.transfer_length = 8'(cur);
                    end
                end
            end
            OP_RESTORE: begin
                // start-up load: only the coordinates are checked, offset taken as is
                if (sec >= NSEC) err = ST_BAD_SECTION;
                else if (ent >= SLOTS) err = ST_BAD_SLOT;
                else begin
                    occupied[sec][ent] = c.flag;
                    fill_level[slot]   = c.offset_value;
                    r.entry_address    = record_at(sec, ent);
                    r.data_addr        = data_at(sec, ent);
                    r.stored_offset    = c.offset_value;
                end
            end
            OP_FINISH: begin
                table_ready = c.flag;
                if (!c.flag) r.status = ST_NOT_INIT;
            end
            OP_FORMAT: begin
                occupied        = '{default: '0};
                fill_level      = '{default: '0};
                table_ready     = 1'b0;
                r.entry_address = rec_base;
                r.stored_offset = '0;
            end
        endcase
        if (err != ST_OK) begin
            r.status          = err;
            r.position        = '0;
            r.entry_address   = '0;
            r.data_addr       = '0;
            r.transfer_length = '0;
        end
        return r;
    endfunction

    function automatic t_req cmd(t_op op, int unsigned sec, int unsigned ent,
                                 int unsigned nlen, int unsigned offv,
                                 int unsigned size, bit flag);
        t_req c;
        c.operation     = op;
        c.section       = 8'(sec);
        c.entry         = 8'(ent);
        c.name_len      = 8'(nlen);
        c.offset_value  = 8'(offv);
        c.transfer_size = 8'(size);
        c.flag          = flag;
        return c;
    endfunction

    // Mostly well-formed traffic on low entries of real sections, so that
    // occupied slots get hit again; the rest is full-range noise.
    function automatic t_req random_cmd();
        t_req        c;
        int unsigned pick;
        if ($urandom_range(99) < 15) begin
            c.operation     = t_op'($urandom_range(7));
            c.section       = 8'($urandom);
            c.entry         = 8'($urandom);
            c.name_len      = 8'($urandom);
            c.offset_value  = 8'($urandom);
            c.transfer_size = 8'($urandom);
            c.flag          = 1'($urandom);
            return c;
        end
        pick = $urandom_range(99);
        if (pick < 22)      c.operation = OP_OCCUPY;
        else if (pick < 32) c.operation = OP_UPDATE;
        else if (pick < 42) c.operation = OP_FREE;
        else if (pick < 64) c.operation = OP_APPEND;
        else if (pick < 80) c.operation = OP_READ;
        else if (pick < 90) c.operation = OP_RESTORE;
        else if (pick < 98) c.operation = OP_FINISH;
        else                c.operation = OP_FORMAT;
        c.section      = 8'($urandom_range(NSEC - 1));
        c.entry        = ($urandom_range(3) == 0) ? 8'($urandom_range(SLOTS - 1))
                                                  : 8'($urandom_range(7));
        c.name_len     = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(MAX_NAME, 1));
        c.offset_value = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(DATA_BYTES));
        if (c.operation == OP_READ)
            c.transfer_size = 8'($urandom_range(255));
        else
            c.transfer_size = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(40));
        c.flag = ($urandom_range(9) != 0);
        return c;
    endfunction

    // Hold off until every word is taken and every result is back, then let
    // the pipeline empty before touching registers or the backlog.
    task automatic settle();
        while (cmd_backlog.size() != 0 || start || due_rsp.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write all three layout registers back to back, only while idle.
    task automatic program_layout(logic [15:0] rec, logic [15:0] dat, logic [15:0] stride);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ENTRY_BASE;
        i_cfg_data <= rec;
        @(posedge i_clk);
        i_cfg_idx  <= REG_DATA_BASE;
        i_cfg_data <= dat;
        @(posedge i_clk);
        i_cfg_idx  <= REG_STRIDE;
        i_cfg_data <= stride;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        rec_base   = rec;
        dat_base   = dat;
        sec_stride = stride;
        @(negedge i_clk);
    endtask

    // Sender: present the head of the backlog, hold it until start meets a
    // low busy, and idle at random in between.
    always @(posedge i_clk) begin : feed
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            // a word is taken on this edge: advance the mirror now
            if (start && !busy)
                due_rsp.push_back(table_response(i_req));
            if (!start || !busy) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    start <= 1'b1;
                    i_req <= cmd_backlog.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Receiver: every strobed result word must match the oldest owed word.
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (i_rst_n && o_done === 1'b1) begin
            rsp_seen++;
            if (due_rsp.size() == 0) begin
                if (mismatches < 10)
                    $display("result %0d: unexpected word st=%0d", rsp_seen, o_rsp.status);
                mismatches++;
            end else begin
                want = due_rsp.pop_front();
                if (o_rsp.status !== want.status || o_rsp.position !== want.position ||
                    o_rsp.entry_address !== want.entry_address ||
                    o_rsp.data_addr !== want.data_addr ||
                    o_rsp.transfer_length !== want.transfer_length ||
                    o_rsp.stored_offset !== want.stored_offset) begin
                    if (mismatches < 10) begin
                        $display("result %0d: got  st=%0d pos=%0d ea=%h da=%h len=%0d off=%0d",
                                 rsp_seen, o_rsp.status, o_rsp.position, o_rsp.entry_address,
                                 o_rsp.data_addr, o_rsp.transfer_length,
                                 o_rsp.stored_offset);
                        $display("result %0d: want st=%0d pos=%0d ea=%h da=%h len=%0d off=%0d",
                                 rsp_seen, want.status, want.position, want.entry_address,
                                 want.data_addr, want.transfer_length,
                                 want.stored_offset);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake must still end the run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sectioned_slot_allocator test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned phase, sec;
        occupied    = '{default: '0};
        fill_level  = '{default: '0};
        table_ready = 1'b0;
        rec_base    = ENTRY_BASE_RST;
        dat_base    = DATA_BASE_RST;
        sec_stride  = STRIDE_RST;
        gap_pct     = 13;
        mismatches  = 0;
        rsp_seen    = 0;
        cycles      = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening under reset layout: not-ready rejections, restore
        // range checks, name limits, offsets beyond the data area, full slot,
        // small buffer, then format and a fresh start-up.
        cmd_backlog.push_back(cmd(OP_OCCUPY,  0, 0, 5, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_UPDATE,  0, 0, 0, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_FINISH,  0, 0, 0, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_RESTORE, 4, 0, 0, 3, 0, 1'b1));
        cmd_backlog.push_back(cmd(OP_RESTORE, 255, 255, 255, 255, 255, 1'b1));
        cmd_backlog.push_back(cmd(OP_RESTORE, 0, 64, 0, 0, 0, 1'b1));
        cmd_backlog.push_back(cmd(OP_RESTORE, 3, 63, 0, 200, 0, 1'b1));
        cmd_backlog.push_back(cmd(OP_RESTORE, 0, 0, 0, 128, 0, 1'b1));
        cmd_backlog.push_back(cmd(OP_FINISH,  0, 0, 0, 0, 0, 1'b1));
        cmd_backlog.push_back(cmd(OP_OCCUPY,  0, 0, 0, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_OCCUPY,  0, 0, MAX_NAME + 1, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_OCCUPY,  4, 0, MAX_NAME, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_OCCUPY,  0, 9, 1, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_APPEND,  0, 1, 0, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_APPEND,  3, 63, 0, 0, 1, 1'b0));
        cmd_backlog.push_back(cmd(OP_READ,    3, 63, 0, 0, 255, 1'b0));
        cmd_backlog.push_back(cmd(OP_APPEND,  0, 0, 0, 0, 1, 1'b0));
        cmd_backlog.push_back(cmd(OP_READ,    0, 0, 0, 0, 127, 1'b0));
        cmd_backlog.push_back(cmd(OP_READ,    0, 0, 0, 0, 128, 1'b0));
        cmd_backlog.push_back(cmd(OP_UPDATE,  0, 0, 0, 129, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_UPDATE,  0, 1, 0, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_APPEND,  0, 1, 0, 0, 128, 1'b0));
        cmd_backlog.push_back(cmd(OP_FREE,    0, 5, 0, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_FREE,    0, 0, 0, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_UPDATE,  5, 0, 0, 0, 0, 1'b0));
        cmd_backlog.push_back(cmd(OP_FORMAT,  0, 0, 0, 0, 0, 1'b0));

        for (phase = 0; phase < 5; phase++) begin
            // new layout for each later phase, extremes first
            case (phase)
                1: program_layout(16'h0000, 16'h0000, 16'h0000);
                2: program_layout(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: program_layout(16'($urandom), 16'($urandom), 16'($urandom));
                4: program_layout(16'hFFF8, 16'hC000, 16'h0100);
                default: ;
            endcase
            gap_pct = 13;
            // start up, then flood one section past its last entry
            cmd_backlog.push_back(cmd(OP_FINISH, 0, 0, 0, 0, 0, 1'b1));
            sec = $urandom_range(NSEC - 1);
            repeat (SLOTS + 2)
                cmd_backlog.push_back(cmd(OP_OCCUPY, sec, $urandom,
                                          $urandom_range(MAX_NAME, 1),
                                          $urandom, $urandom, 1'($urandom)));
            repeat (60) cmd_backlog.push_back(random_cmd());
            settle();
            // one stretch with a sender that never idles
            if (phase == 2) gap_pct = 0;
            repeat (60) cmd_backlog.push_back(random_cmd());
            settle();
        end

        if (mismatches == 0) begin
            $display("sectioned_slot_allocator test passed");
        end else begin
            $display("sectioned_slot_allocator test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/sla_pkg.sv
hdl/sla_vmem.sv
hdl/sla_free_find.sv
hdl/sla_addr_calc.sv
hdl/sectioned_slot_allocator.sv
hdl/sla_port_chk.sv
bench/tb.sv
